// ===== hdl/tcw_pkg.sv =====
// Shared types and constants for the text console writer.
package tcw_pkg;

    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [7:0]  CHAR_NEWLINE = 8'd10;
    localparam logic [7:0]  CHAR_RETURN  = 8'd13;
    localparam logic [7:0]  ATTR_RESET   = 8'h0F;
    localparam logic [15:0] RESET_CELL   = 16'h0F00;
    localparam logic [15:0] ZERO_CELL    = 16'h0000;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] char_code;
        logic [4:0] read_row;
        logic [6:0] read_col;
    } t_in_word;

    typedef struct packed {
        logic [15:0] cell_data;
        logic [4:0]  cursor_row;
        logic [6:0]  cursor_col;
        logic        scrolled;
    } t_out_word;

    typedef enum logic [2:0] {
        K_NOP,
        K_PUT,
        K_NEWLINE,
        K_RETURN,
        K_READ,
        K_CLEAR
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] char_code;
        logic       rd_ok;
        logic [4:0] read_row;
        logic [6:0] read_col;
    } t_cmd;

endpackage

// ===== hdl/text_console_writer.sv =====
// Top level of the text console writer: front end, command queue, back end.
//
// Input channel (i_in_valid / o_in_stall / i_in_word): a word is taken at a
// clock edge with valid high and stall low. Ops: put character (newline and
// carriage return handled), read cell, clear screen. Output channel
// (o_out_valid / i_out_stall / o_out_word): exactly one result word per
// input word, in order, holding the read cell (zero otherwise), the cursor
// after the op, and a scroll flag. i_cfg_we / i_cfg_data write the attribute.
//
// Cursor-only ops and puts finish in the cycle they leave the queue, unless they
// scroll; a read passes through S_READ for the registered memory port. Clear
// sweeps the screen memory, one cell a cycle. A scroll copies through the single
// write port, one cell a cycle, then zeroes the bottom row. The front end keeps
// taking words into a two-entry queue meanwhile, until the queue is full.
//
// Reset (synchronous, i_rst_n low) clears the cursor, sets the attribute to
// 0x0F and starts a pass that writes 0x0F00 into all ROWS*COLUMNS cells;
// no command is executed until it ends. A stalled result holds in the output
// register, and the back end waits on it before taking the next command.
module text_console_writer #(
    parameter int ROWS    = 25,
    parameter int COLUMNS = 80
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  tcw_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output tcw_pkg::t_out_word o_out_word,
    input  logic               i_cfg_we,
    input  logic [7:0]         i_cfg_data
);
    import tcw_pkg::*;

    t_cmd front_cmd;
    t_cmd queue_cmd;
    logic front_push;
    logic queue_full;
    logic queue_empty;
    logic back_pop;

    // Classify incoming words; stall only when the queue is full.
    tcw_front #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) u_front (
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_word  (i_in_word),
        .i_full  (queue_full),
        .o_push  (front_push),
        .o_cmd   (front_cmd)
    );

    // Decouple the front end from long back-end sweeps.
    tcw_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_cmd   (front_cmd),
        .i_pop   (back_pop),
        .o_cmd   (queue_cmd),
        .o_full  (queue_full),
        .o_empty (queue_empty)
    );

    // Execute commands against the screen memory and cursor.
    tcw_back #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_cmd_valid (!queue_empty),
        .i_cmd       (queue_cmd),
        .o_cmd_pop   (back_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

endmodule

// ===== hdl/tcw_front.sv =====
// Front end: accepts input words and classifies them into back-end commands.
module tcw_front #(
    parameter int ROWS    = 25,
    parameter int COLUMNS = 80
) (
    input  logic              i_valid,
    output logic              o_stall,
    input  tcw_pkg::t_in_word i_word,
    input  logic              i_full,
    output logic              o_push,
    output tcw_pkg::t_cmd     o_cmd
);
    import tcw_pkg::*;

    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        o_cmd.char_code = i_word.char_code;
        o_cmd.read_row  = i_word.read_row;
        o_cmd.read_col  = i_word.read_col;
        o_cmd.rd_ok     = (32'(i_word.read_row) < ROWS) && (32'(i_word.read_col) < COLUMNS);
        case (i_word.op)
            OP_PUT: begin
                if (i_word.char_code == CHAR_NEWLINE) begin
                    o_cmd.kind = K_NEWLINE;
                end else if (i_word.char_code == CHAR_RETURN) begin
                    o_cmd.kind = K_RETURN;
                end else begin
                    o_cmd.kind = K_PUT;
                end
            end
            OP_READ:  o_cmd.kind = K_READ;
            OP_CLEAR: o_cmd.kind = K_CLEAR;
            default:  o_cmd.kind = K_NOP;
        endcase
    end

endmodule

// ===== hdl/tcw_fifo.sv =====
// Two-entry command queue between the front and back ends.
module tcw_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tcw_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output tcw_pkg::t_cmd o_cmd,
    output logic          o_full,
    output logic          o_empty
);
    import tcw_pkg::*;

    t_cmd       r_slot [2];
    logic       r_wp, n_wp;
    logic       r_rp, n_rp;
    logic [1:0] r_count, n_count;

    assign o_cmd   = r_slot[r_rp];
    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);

    always_comb begin
        n_wp    = r_wp ^ i_push;
        n_rp    = r_rp ^ i_pop;
        n_count = r_count + {1'b0, i_push} - {1'b0, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_cmd;
        end
    end

endmodule

// ===== hdl/tcw_back.sv =====
// Back end: screen memory, cursor, fill and scroll sweeps, result register.
module tcw_back #(
    parameter int ROWS    = 25,
    parameter int COLUMNS = 80
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [7:0]         i_cfg_data,
    input  logic               i_cmd_valid,
    input  tcw_pkg::t_cmd      i_cmd,
    output logic               o_cmd_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output tcw_pkg::t_out_word o_out_word
);
    import tcw_pkg::*;

    localparam int CELLS  = ROWS * COLUMNS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLUMNS);

    localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] COPY_END  = ADDR_W'(CELLS - COLUMNS);
    localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(COLUMNS);
    localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(COLUMNS - 1);

    localparam logic [1:0] S_FILL   = 2'd0;
    localparam logic [1:0] S_IDLE   = 2'd1;
    localparam logic [1:0] S_READ   = 2'd2;
    localparam logic [1:0] S_SCROLL = 2'd3;

    logic [1:0]        r_state, n_state;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [COL_W-1:0]  r_col, n_col;
    logic [ADDR_W-1:0] r_base, n_base;
    logic [7:0]        r_attr;
    logic [ADDR_W-1:0] r_sweep, n_sweep;
    logic [15:0]       r_fill, n_fill;
    logic              r_reply, n_reply;
    logic              r_scr, n_scr;
    logic              r_pend, n_pend;
    logic [ADDR_W-1:0] r_dst, n_dst;
    logic              r_out_valid, n_out_valid;
    t_out_word         r_out, n_out;

    logic [15:0]       r_mem [CELLS];
    logic [15:0]       r_rd_data;

    logic              w_we;
    logic [ADDR_W-1:0] w_waddr;
    logic [15:0]       w_wdata;
    logic              w_re;
    logic [ADDR_W-1:0] w_raddr;
    logic              out_free;
    logic              newline;
    logic              reply;

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    always_comb begin
        n_state     = r_state;
        n_row       = r_row;
        n_col       = r_col;
        n_base      = r_base;
        n_sweep     = r_sweep;
        n_fill      = r_fill;
        n_reply     = r_reply;
        n_scr       = r_scr;
        n_pend      = r_pend;
        n_dst       = r_dst;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        w_we        = 1'b0;
        w_waddr     = r_sweep;
        w_wdata     = r_fill;
        w_re        = 1'b0;
        w_raddr     = r_sweep + ROW_STEP;
        o_cmd_pop   = 1'b0;
        newline     = 1'b0;
        reply       = 1'b0;
        out_free    = !r_out_valid || !i_out_stall;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_FILL: begin
                w_we    = 1'b1;
                n_sweep = r_sweep + 1'b1;
                if (r_sweep == LAST_CELL) begin
                    n_state = S_IDLE;
                    if (r_reply) begin
                        n_out_valid      = 1'b1;
                        n_out.cell_data  = ZERO_CELL;
                        n_out.cursor_row = 5'(r_row);
                        n_out.cursor_col = 7'(r_col);
                        n_out.scrolled   = r_scr;
                    end
                end
            end
            S_IDLE: begin
                if (i_cmd_valid && out_free) begin
                    o_cmd_pop = 1'b1;
                    case (i_cmd.kind)
                        K_PUT: begin
                            w_we    = 1'b1;
                            w_waddr = r_base + ADDR_W'(r_col);
                            w_wdata = {r_attr, i_cmd.char_code};
                            if (r_col == LAST_COL) begin
                                newline = 1'b1;
                            end else begin
                                n_col = r_col + 1'b1;
                                reply = 1'b1;
                            end
                        end
                        K_NEWLINE: newline = 1'b1;
                        K_RETURN: begin
                            n_col = '0;
                            reply = 1'b1;
                        end
                        K_READ: begin
                            if (i_cmd.rd_ok) begin
                                w_re    = 1'b1;
                                w_raddr = ADDR_W'(i_cmd.read_row) * ROW_STEP
                                        + ADDR_W'(i_cmd.read_col);
                                n_state = S_READ;
                            end else begin
                                reply = 1'b1;
                            end
                        end
                        K_CLEAR: begin
                            n_fill  = {r_attr, 8'h00};
                            n_sweep = '0;
                            n_reply = 1'b1;
                            n_scr   = 1'b0;
                            n_state = S_FILL;
                        end
                        default: reply = 1'b1;
                    endcase

                    // Row advance: scroll from the last row, else step down.
                    if (newline) begin
                        n_col = '0;
                        if (r_row == LAST_ROW) begin
                            n_sweep = '0;
                            n_pend  = 1'b0;
                            n_state = S_SCROLL;
                        end else begin
                            n_row  = r_row + 1'b1;
                            n_base = r_base + ROW_STEP;
                            reply  = 1'b1;
                        end
                    end

                    if (reply) begin
                        n_out_valid      = 1'b1;
                        n_out.cell_data  = ZERO_CELL;
                        n_out.cursor_row = 5'(n_row);
                        n_out.cursor_col = 7'(n_col);
                        n_out.scrolled   = 1'b0;
                    end
                end
            end
            S_READ: begin
                n_out_valid      = 1'b1;
                n_out.cell_data  = r_rd_data;
                n_out.cursor_row = 5'(r_row);
                n_out.cursor_col = 7'(r_col);
                n_out.scrolled   = 1'b0;
                n_state          = S_IDLE;
            end
            S_SCROLL: begin
                // Read one row down, write the cell fetched last cycle.
                if (r_pend) begin
                    w_we    = 1'b1;
                    w_waddr = r_dst;
                    w_wdata = r_rd_data;
                end
                if (r_sweep != COPY_END) begin
                    w_re    = 1'b1;
                    w_raddr = r_sweep + ROW_STEP;
                    n_dst   = r_sweep;
                    n_pend  = 1'b1;
                    n_sweep = r_sweep + 1'b1;
                end else begin
                    n_pend  = 1'b0;
                    n_fill  = ZERO_CELL;
                    n_reply = 1'b1;
                    n_scr   = 1'b1;
                    n_state = S_FILL;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_FILL;
            r_row       <= '0;
            r_col       <= '0;
            r_base      <= '0;
            r_attr      <= ATTR_RESET;
            r_sweep     <= '0;
            r_fill      <= RESET_CELL;
            r_reply     <= 1'b0;
            r_scr       <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row       <= n_row;
            r_col       <= n_col;
            r_base      <= n_base;
            r_sweep     <= n_sweep;
            r_fill      <= n_fill;
            r_reply     <= n_reply;
            r_scr       <= n_scr;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_attr <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_dst <= n_dst;
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_re) begin
            r_rd_data <= r_mem[w_raddr];
        end
    end

endmodule

// ===== hdl/tcw_checker.sv =====
// Port-level assertions for the text console writer, bound to the top level.
module tcw_checker #(
    parameter int ROWS    = 25,
    parameter int COLUMNS = 80
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input tcw_pkg::t_out_word o_out_word
);
    import tcw_pkg::*;

    // No result is shown right after reset.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("stalled result changed");

    // A scroll leaves the cursor at the start of the bottom row.
    a_scroll_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.scrolled |->
            o_out_word.cursor_row == 5'(ROWS - 1) && o_out_word.cursor_col == 7'd0)
        else $error("scroll with cursor off the bottom row start");

    // The cursor stays on the screen.
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            32'(o_out_word.cursor_row) < ROWS && 32'(o_out_word.cursor_col) < COLUMNS)
        else $error("cursor off screen");

endmodule

bind text_console_writer tcw_checker #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
) u_tcw_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);

// ===== bench/tb.sv =====
// Self-checking bench for the text console writer: a directed table, then randomized traffic.
`timescale 1ns / 1ps

module tb;
    import tcw_pkg::*;

    localparam int ROWS    = 25;
    localparam int COLUMNS = 80;
    localparam int CELLS   = ROWS * COLUMNS;

    // The package names ops 0..2 only; op 3 must leave the console untouched.
    localparam logic [1:0] OP_SPARE = 2'd3;

    localparam int DIR_ROWS       = 25;
    localparam int PHASES         = 8;
    localparam int PHASE_WORDS    = 241;
    localparam int IDLE_PCT       = 13;
    localparam int CALM_FIRST     = 1000;   // no gaps or stalls for words in this window
    localparam int CALM_LAST      = 1300;
    localparam int HOLD_AT        = 600;    // long output stall starts after this many results
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 20000;  // a scroll or a clear sweeps every screen cell
    localparam int DRAIN_CYCLES   = 50;

    // Attribute per random phase, phase 0 in the low byte. Phases 3 and 6 draw a random
    // byte instead of the slot value.
    localparam logic [PHASES*8-1:0] ATTR_PLAN =
        {8'hF0, 8'h00, 8'h07, 8'h80, 8'h00, 8'h1E, 8'hFF, 8'h00};

    typedef struct packed {
        t_in_word  stim;
        logic      fixed;   // want below is typed in; otherwise the shadow console decides
        t_out_word want;
    } t_dir_row;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic       o_in_stall;
    t_in_word   i_in_word   = '0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    t_out_word  o_out_word;
    logic       i_cfg_we    = 1'b0;
    logic [7:0] i_cfg_data  = 8'h00;

    // Shadow copy of the console: screen, cursor and attribute.
    logic [15:0] shadow_screen [CELLS];
    int          cur_row;
    int          cur_col;
    logic [7:0]  cur_attr;

    t_out_word status_due [$];   // status words owed by the block, oldest first
    t_out_word due_word;
    t_dir_row  dir_tab [DIR_ROWS];

    int mismatches   = 0;
    int words_sent   = 0;
    int results_seen = 0;
    int n_puts       = 0;
    int n_reads      = 0;
    int n_clears     = 0;
    int n_spare      = 0;
    int n_scrolls    = 0;
    int hold_left    = 0;
    bit hold_done    = 1'b0;
    int idle_cycles  = 0;

    text_console_writer #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Print one line per mismatch and count every one.
    task automatic log_mismatch(string msg);
        mismatches++;
        $display("%0t MISMATCH: %s", $time, msg);
    endtask

    task automatic check_field(string name, int idx, logic [15:0] got, logic [15:0] want);
        if (got !== want) begin
            log_mismatch($sformatf("status word %0d %s: got 0x%0h, want 0x%0h",
                                   idx, name, got, want));
        end
    endtask

    // Move the cursor down one row; scroll the shadow screen when it runs off the bottom.
    // The freshly exposed bottom row is all zero, with no attribute.
    function automatic logic bump_row();
        cur_row++;
        if (cur_row < ROWS) return 1'b0;
        cur_row = ROWS - 1;
        for (int i = 0; i < CELLS - COLUMNS; i++) shadow_screen[i] = shadow_screen[i + COLUMNS];
        for (int i = CELLS - COLUMNS; i < CELLS; i++) shadow_screen[i] = ZERO_CELL;
        return 1'b1;
    endfunction

    // Apply one accepted word to the shadow console and return the status word it owes.
    function automatic t_out_word emulate_console(t_in_word w);
        t_out_word r;
        r = '0;
        case (w.op)
            OP_PUT: begin
                if (w.char_code == CHAR_NEWLINE) begin
                    cur_col = 0;
                    r.scrolled = bump_row();
                end else if (w.char_code == CHAR_RETURN) begin
                    cur_col = 0;
                end else begin
                    // Any other byte, zero included, lands at the cursor.
                    shadow_screen[cur_row * COLUMNS + cur_col] = {cur_attr, w.char_code};
                    cur_col++;
                    if (cur_col >= COLUMNS) begin
                        cur_col = 0;
                        r.scrolled = bump_row();
                    end
                end
            end
            OP_READ: begin
                // Out-of-range coordinates read back as zero.
                if (w.read_row < ROWS && w.read_col < COLUMNS) begin
                    r.cell_data = shadow_screen[w.read_row * COLUMNS + w.read_col];
                end
            end
            OP_CLEAR: begin
                for (int i = 0; i < CELLS; i++) shadow_screen[i] = {cur_attr, 8'h00};
            end
            default: begin
            end
        endcase
        r.cursor_row = 5'(cur_row);
        r.cursor_col = 7'(cur_col);
        return r;
    endfunction

    function automatic t_dir_row dir_entry(logic [1:0] op, logic [7:0] ch, logic [4:0] rr,
                                           logic [6:0] rc, logic fixed, logic [15:0] data);
        t_dir_row e;
        e.stim  = {op, ch, rr, rc};
        e.fixed = fixed;
        e.want  = {data, 5'd0, 7'd0, 1'b0};
        return e;
    endfunction

    // Offer one word, with random gaps in front of it, and hold it until the block takes it.
    // Book the owed status word at the edge that accepts it.
    task automatic send_word(t_in_word w, logic fixed, t_out_word want);
        t_out_word predicted;
        while (!(words_sent >= CALM_FIRST && words_sent < CALM_LAST)
               && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predicted = emulate_console(w);
        status_due.push_back(fixed ? want : predicted);
        words_sent++;
        if (predicted.scrolled) n_scrolls++;
        case (w.op)
            OP_PUT:   n_puts++;
            OP_READ:  n_reads++;
            OP_CLEAR: n_clears++;
            default:  n_spare++;
        endcase
    endtask

    // Output side: check each accepted status word against the oldest one owed, then pick
    // the stall for the next cycle. Once, hold off for a long stretch so the block backs up
    // and stalls its input while the sender keeps offering.
    always @(posedge i_clk) begin
        if (o_out_valid && !i_out_stall) begin
            if (status_due.size() == 0) begin
                log_mismatch($sformatf("status word %0d arrived with nothing owed",
                                       results_seen));
            end else begin
                due_word = status_due.pop_front();
                check_field("cell_data", results_seen, o_out_word.cell_data, due_word.cell_data);
                check_field("cursor_row", results_seen, 16'(o_out_word.cursor_row),
                            16'(due_word.cursor_row));
                check_field("cursor_col", results_seen, 16'(o_out_word.cursor_col),
                            16'(due_word.cursor_col));
                check_field("scrolled", results_seen, 16'(o_out_word.scrolled),
                            16'(due_word.scrolled));
            end
            results_seen++;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (!hold_done && results_seen >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= !(results_seen >= CALM_FIRST && results_seen < CALM_LAST)
                           && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // Give up when no word moves on either side for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        t_in_word   w;
        logic [7:0] attr_val;
        int         pick;

        for (int i = 0; i < CELLS; i++) shadow_screen[i] = RESET_CELL;
        cur_row  = 0;
        cur_col  = 0;
        cur_attr = ATTR_RESET;

        // Directed words. The first rows come straight after reset with the cursor at the
        // origin, so their status words are typed in; the rest go through the shadow console.
        dir_tab[0]  = dir_entry(OP_READ,  8'h00,        5'd0,  7'd0,   1'b1, RESET_CELL);
        dir_tab[1]  = dir_entry(OP_READ,  8'h00,        5'd24, 7'd79,  1'b1, RESET_CELL);
        dir_tab[2]  = dir_entry(OP_READ,  8'h00,        5'd25, 7'd0,   1'b1, ZERO_CELL);
        dir_tab[3]  = dir_entry(OP_READ,  8'hFF,        5'd31, 7'd127, 1'b1, ZERO_CELL);
        dir_tab[4]  = dir_entry(OP_READ,  8'h00,        5'd0,  7'd80,  1'b1, ZERO_CELL);
        dir_tab[5]  = dir_entry(OP_SPARE, 8'hFF,        5'd31, 7'd127, 1'b1, ZERO_CELL);
        dir_tab[6]  = dir_entry(OP_SPARE, 8'h00,        5'd0,  7'd0,   1'b1, ZERO_CELL);
        dir_tab[7]  = dir_entry(OP_PUT,   8'h41,        5'd0,  7'd0,   1'b0, ZERO_CELL);
        dir_tab[8]  = dir_entry(OP_PUT,   8'h00,        5'd0,  7'd0,   1'b0, ZERO_CELL);
        dir_tab[9]  = dir_entry(OP_PUT,   8'hFF,        5'd31, 7'd127, 1'b0, ZERO_CELL);
        dir_tab[10] = dir_entry(OP_PUT,   8'h80,        5'd0,  7'd0,   1'b0, ZERO_CELL);
        dir_tab[11] = dir_entry(OP_PUT,   CHAR_RETURN,  5'd0,  7'd0,   1'b0, ZERO_CELL);
        dir_tab[12] = dir_entry(OP_PUT,   8'h7F,        5'd0,  7'd0,   1'b0, ZERO_CELL);
        dir_tab[13] = dir_entry(OP_PUT,   CHAR_NEWLINE, 5'd0,  7'd0,   1'b0, ZERO_CELL);
        dir_tab[14] = dir_entry(OP_PUT,   8'h55,        5'h15, 7'h2A,  1'b0, ZERO_CELL);
        dir_tab[15] = dir_entry(OP_READ,  8'h00,        5'd0,  7'd0,   1'b0, ZERO_CELL);
        dir_tab[16] = dir_entry(OP_READ,  8'h00,        5'd0,  7'd1,   1'b0, ZERO_CELL);
        dir_tab[17] = dir_entry(OP_READ,  8'h00,        5'd0,  7'd3,   1'b0, ZERO_CELL);
        dir_tab[18] = dir_entry(OP_READ,  8'h00,        5'd1,  7'd0,   1'b0, ZERO_CELL);
        dir_tab[19] = dir_entry(OP_READ,  8'h00,        5'd1,  7'd1,   1'b0, ZERO_CELL);
        dir_tab[20] = dir_entry(OP_SPARE, 8'h00,        5'd24, 7'd79,  1'b0, ZERO_CELL);
        dir_tab[21] = dir_entry(OP_CLEAR, 8'hAA,        5'd5,  7'd5,   1'b0, ZERO_CELL);
        dir_tab[22] = dir_entry(OP_READ,  8'h00,        5'd0,  7'd0,   1'b0, ZERO_CELL);
        dir_tab[23] = dir_entry(OP_READ,  8'h00,        5'd24, 7'd79,  1'b0, ZERO_CELL);
        dir_tab[24] = dir_entry(OP_PUT,   8'h20,        5'd0,  7'd0,   1'b0, ZERO_CELL);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the table with the reset attribute.
        for (int k = 0; k < DIR_ROWS; k++) begin
            send_word(dir_tab[k].stim, dir_tab[k].fixed, dir_tab[k].want);
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            // Drain, then change the attribute while the block is idle.
            i_in_valid <= 1'b0;
            while (status_due.size() != 0) @(posedge i_clk);
            @(posedge i_clk);
            attr_val = (ph == 3 || ph == 6) ? 8'($urandom) : ATTR_PLAN[ph*8 +: 8];
            i_cfg_we   <= 1'b1;
            i_cfg_data <= attr_val;
            @(posedge i_clk);
            i_cfg_we <= 1'b0;
            cur_attr = attr_val;

            // Random words: mostly puts and reads, occasional clears and spare ops.
            // Unused fields stay random so every input bit toggles.
            for (int n = 0; n < PHASE_WORDS; n++) begin
                w.char_code = 8'($urandom);
                w.read_row  = 5'($urandom);
                w.read_col  = 7'($urandom);
                pick = $urandom_range(0, 999);
                if (pick < 6) begin
                    w.op = OP_CLEAR;
                end else if (pick < 25) begin
                    w.op = OP_SPARE;
                end else if (pick < 400) begin
                    w.op = OP_READ;
                    // Keep a few reads anywhere in the field range; aim the rest on screen,
                    // many of them at the cursor row where writes and scrolls land.
                    if (pick >= 60) begin
                        w.read_row = (pick < 230) ? 5'(cur_row)
                                                  : 5'($urandom_range(0, ROWS - 1));
                        w.read_col = 7'($urandom_range(0, COLUMNS - 1));
                    end
                end else begin
                    w.op = OP_PUT;
                    if (pick < 440) begin
                        w.char_code = CHAR_NEWLINE;
                    end else if (pick < 460) begin
                        w.char_code = CHAR_RETURN;
                    end
                end
                send_word(w, 1'b0, '0);
            end
        end

        // Drain the last status words and leave room for anything unrequested.
        i_in_valid <= 1'b0;
        while (status_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d words: %0d puts, %0d reads, %0d clears, %0d spare ops",
                 words_sent, n_puts, n_reads, n_clears, n_spare);
        $display("Checked %0d status words, %0d scrolls, %0d attribute settings",
                 results_seen, n_scrolls, PHASES + 1);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
